// ----- hw/rtl/tchvf_pkg.sv -----
// Shared types and constants for the TLS ClientHello version filter.
// No dependencies; imported by tls_client_hello_version_filter_core.
`default_nettype none

package tchvf_pkg;

   // Verdict codes carried in the result word.
   typedef enum logic [2:0] {
      VERDICT_OLD_VERSION    = 3'd0,
      VERDICT_VERSION_OK     = 3'd1,
      VERDICT_BAD_IP_LEN     = 3'd2,
      VERDICT_NOT_TCP        = 3'd3,
      VERDICT_BAD_TCP_LEN    = 3'd4,
      VERDICT_NOT_HANDSHAKE  = 3'd5,
      VERDICT_NOT_HELLO      = 3'd6,
      VERDICT_TRUNCATED      = 3'd7
   } verdict_type;

   // Protocol values that the filter looks for.
   localparam logic [7:0]  IP_PROTO_TCP        = 8'd6;
   localparam logic [7:0]  TLS_CT_HANDSHAKE    = 8'd22;
   localparam logic [7:0]  TLS_HS_CLIENT_HELLO = 8'd1;
   localparam logic [3:0]  MIN_HDR_WORDS       = 4'd5;
   localparam logic [15:0] MIN_VERSION_RESET   = 16'h0301;

   // Byte offsets from the start of the IPv4 header.
   localparam int IP_OFS_PROTOCOL = 9;
   localparam int IP_OFS_SRC      = 12;
   localparam int IP_OFS_DST      = 16;
   localparam int IP_OFS_END      = 20;
   localparam int TCP_OFS_DOFF    = 12;

   // Byte offsets from the start of the TCP payload.
   localparam int PAY_OFS_RECORD  = 0;
   localparam int PAY_OFS_HS_TYPE = 5;
   localparam int PAY_OFS_VER_HI  = 9;
   localparam int PAY_OFS_VER_LO  = 10;

   // Bits of the seen-bytes mask.
   localparam int SEEN_RECORD  = 0;
   localparam int SEEN_HS_TYPE = 1;
   localparam int SEEN_VER_HI  = 2;
   localparam int SEEN_VER_LO  = 3;

   localparam int RSP_DATA_BITS = 88;

endpackage

`default_nettype wire

// ----- hw/rtl/tls_client_hello_version_filter_core.sv -----
// TLS ClientHello version filter, top level.
// Depends on tchvf_pkg for verdict codes and header offsets.
`default_nettype none

// The block takes an Ethernet frame one byte per word on the req_ stream and
// gives one result word on the rsp_ stream for each frame, after the word
// marked with req_tlast. It picks the IPv4 header length, protocol and both
// addresses, the TCP data offset, then the TLS record type, handshake type
// and ClientHello version from the TCP payload, and reports the frame when
// it is a handshake ClientHello whose version is strictly below the
// min_version register (written through csr_we/csr_wdata, reset 0x0301).
// The ethertype is not checked. The verdict code names the first check that
// failed, or truncation when the frame ended before the byte that check
// needed. The block takes one byte every clock cycle while its input is not
// stalled; a byte passes an input register and then the parsing and verdict
// logic, and the result word for a frame is loaded into an output register
// when the frame's last byte leaves the input register. The result sits in
// the output register, and while it waits the block keeps accepting
// bytes of the next frame until that frame's last byte reaches the input
// register; only then is the input stalled until the result is taken.
module tls_client_hello_version_filter_core #(
   parameter int LINK_HEADER_BYTES = 14,
   parameter int POSITION_BITS     = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   // Frame bytes: [7:0] frame_byte.
   input  wire  [7:0]                         req_tdata,
   input  wire                                req_tlast,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // Result: [2:0] verdict, [3] report, [19:4] client_version,
   // [51:20] source_address, [83:52] destination_address, [87:84] zero.
   output logic [tchvf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // Minimum accepted version register.
   input  wire                                csr_we,
   input  wire  [15:0]                        csr_wdata
);
   import tchvf_pkg::*;

   // Positions are compared one bit wider than the counter, which gives header
   // offsets headroom beyond the counter's range.
   localparam int CW = POSITION_BITS + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [CW-1:0] IP_BASE = CW'(LINK_HEADER_BYTES);

   // Configuration register.
   logic [15:0] min_version_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_version_ff <= MIN_VERSION_RESET;
      end else if (csr_we) begin
         min_version_ff <= csr_wdata;
      end
   end

   // Input stage: byte, last flag and the byte's position in the frame.
   logic                     req_fire;
   logic                     s1_go;
   logic                     s1_vld_ff, s1_vld_in;
   logic [7:0]               s1_byte_ff;
   logic                     s1_last_ff;
   logic [POSITION_BITS-1:0] s1_pos_ff;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   // The input stage moves on unless it holds a last byte whose result has
   // nowhere to go.
   assign s1_go      = s1_vld_ff && (!s1_last_ff || !rsp_tvalid || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_fire) begin
         s1_vld_in = 1'b1;
      end else if (s1_go) begin
         s1_vld_in = 1'b0;
      end
   end

   // The position counter saturates and restarts after each frame.
   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         if (req_tlast) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
         s1_pos_ff  <= pos_ff;
      end
   end

   // Per-frame parse state.
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  doff_ff, doff_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [7:0]  record_ff, record_in;
   logic [7:0]  hs_kind_ff, hs_kind_in;
   logic [15:0] version_ff, version_in;
   logic [3:0]  seen_ff, seen_in;

   logic [CW-1:0] p;
   logic [3:0]    ihl_eff;
   logic [CW-1:0] tcp_pos;
   logic [CW-1:0] pay_pos;
   logic          past_ip_base;

   assign p            = {1'b0, s1_pos_ff};
   // The header length byte counts for the TCP offset at once.
   assign ihl_eff      = (p == IP_BASE) ? s1_byte_ff[3:0] : ihl_ff;
   assign tcp_pos      = IP_BASE + CW'({ihl_eff, 2'b00}) + CW'(TCP_OFS_DOFF);
   assign pay_pos      = IP_BASE + CW'({ihl_eff, 2'b00}) + CW'({doff_ff, 2'b00});
   assign past_ip_base = p > IP_BASE;

   always_comb begin
      ihl_in     = ihl_eff;
      proto_in   = proto_ff;
      doff_in    = doff_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      record_in  = record_ff;
      hs_kind_in = hs_kind_ff;
      version_in = version_ff;
      seen_in    = seen_ff;

      // IPv4 header fields.
      if (p == IP_BASE + CW'(IP_OFS_PROTOCOL)) begin
         proto_in = s1_byte_ff;
      end else if (p >= IP_BASE + CW'(IP_OFS_SRC) && p < IP_BASE + CW'(IP_OFS_DST)) begin
         src_in = {src_ff[23:0], s1_byte_ff};
      end else if (p >= IP_BASE + CW'(IP_OFS_DST) && p < IP_BASE + CW'(IP_OFS_END)) begin
         dst_in = {dst_ff[23:0], s1_byte_ff};
      end

      // TCP data offset, then the TLS bytes of the payload.
      if (past_ip_base && p == tcp_pos) begin
         doff_in = s1_byte_ff[7:4];
      end else if (past_ip_base && p > tcp_pos) begin
         if (p == pay_pos + CW'(PAY_OFS_RECORD)) begin
            record_in             = s1_byte_ff;
            seen_in[SEEN_RECORD]  = 1'b1;
         end else if (p == pay_pos + CW'(PAY_OFS_HS_TYPE)) begin
            hs_kind_in            = s1_byte_ff;
            seen_in[SEEN_HS_TYPE] = 1'b1;
         end else if (p == pay_pos + CW'(PAY_OFS_VER_HI)) begin
            version_in[15:8]      = s1_byte_ff;
            seen_in[SEEN_VER_HI]  = 1'b1;
         end else if (p == pay_pos + CW'(PAY_OFS_VER_LO)) begin
            version_in[7:0]       = s1_byte_ff;
            seen_in[SEEN_VER_LO]  = 1'b1;
         end
      end
   end

   // Verdict on the state as it stands after the current byte. Each check
   // first asks whether the byte it needs has arrived.
   verdict_type verdict;

   always_comb begin
      if (p < IP_BASE) begin
         verdict = VERDICT_TRUNCATED;
      end else if (ihl_in < MIN_HDR_WORDS) begin
         verdict = VERDICT_BAD_IP_LEN;
      end else if (p < IP_BASE + CW'(IP_OFS_PROTOCOL)) begin
         verdict = VERDICT_TRUNCATED;
      end else if (proto_in != IP_PROTO_TCP) begin
         verdict = VERDICT_NOT_TCP;
      end else if (p < tcp_pos) begin
         verdict = VERDICT_TRUNCATED;
      end else if (doff_in < MIN_HDR_WORDS) begin
         verdict = VERDICT_BAD_TCP_LEN;
      end else if (!seen_in[SEEN_RECORD]) begin
         verdict = VERDICT_TRUNCATED;
      end else if (record_in != TLS_CT_HANDSHAKE) begin
         verdict = VERDICT_NOT_HANDSHAKE;
      end else if (!seen_in[SEEN_HS_TYPE]) begin
         verdict = VERDICT_TRUNCATED;
      end else if (hs_kind_in != TLS_HS_CLIENT_HELLO) begin
         verdict = VERDICT_NOT_HELLO;
      end else if (!(seen_in[SEEN_VER_HI] && seen_in[SEEN_VER_LO])) begin
         verdict = VERDICT_TRUNCATED;
      end else if (version_in < min_version_ff) begin
         verdict = VERDICT_OLD_VERSION;
      end else begin
         verdict = VERDICT_VERSION_OK;
      end
   end

   // Parse state advances with each byte and clears after the frame's last.
   always_ff @(posedge clock) begin
      if (reset || (s1_go && s1_last_ff)) begin
         ihl_ff     <= '0;
         proto_ff   <= '0;
         doff_ff    <= '0;
         src_ff     <= '0;
         dst_ff     <= '0;
         record_ff  <= '0;
         hs_kind_ff <= '0;
         version_ff <= '0;
         seen_ff    <= '0;
      end else if (s1_go) begin
         ihl_ff     <= ihl_in;
         proto_ff   <= proto_in;
         doff_ff    <= doff_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         record_ff  <= record_in;
         hs_kind_ff <= hs_kind_in;
         version_ff <= version_in;
         seen_ff    <= seen_in;
      end
   end

   // Result register.
   logic        rsp_load;
   logic        rsp_vld_ff, rsp_vld_in;
   verdict_type rsp_verdict_ff;
   logic        rsp_report_ff;
   logic [15:0] rsp_version_ff;
   logic [31:0] rsp_src_ff;
   logic [31:0] rsp_dst_ff;

   assign rsp_load = s1_go && s1_last_ff;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_verdict_ff <= verdict;
         rsp_report_ff  <= (verdict == VERDICT_OLD_VERSION);
         rsp_version_ff <= version_in;
         rsp_src_ff     <= src_in;
         rsp_dst_ff     <= dst_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_dst_ff, rsp_src_ff, rsp_version_ff,
                        rsp_report_ff, rsp_verdict_ff};

   // After a frame's last byte is taken the position counter starts again.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (pos_ff == '0))
      else $error("position counter not restarted after last word");

   // A result only appears when a last byte left the input stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s1_go && s1_last_ff))
      else $error("result word without a frame end");

   // Frame state is cleared once the last byte has been judged.
   assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (seen_ff == '0 && ihl_ff == '0 && doff_ff == '0))
      else $error("parse state not cleared after frame end");

   // A reported frame really carries a version below the minimum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_report_ff) |-> (rsp_version_ff < min_version_ff))
      else $error("reported version not below minimum");

endmodule

`default_nettype wire

// ----- sim/tls_client_hello_version_filter_core_test.sv -----
// Self-checking testbench for the TLS ClientHello version filter core.
// Depends on tchvf_pkg and tls_client_hello_version_filter_core only; it
// predicts each frame's verdict word and compares it with the block's output.
`timescale 1ns / 100ps

module tls_client_hello_version_filter_core_test;
   import tchvf_pkg::*;

   localparam int LINK_BYTES     = 14;
   // A narrow counter keeps the saturation test short; no field lies near it.
   localparam int POS_BITS       = 8;
   // Settling wait after the last owed result word is taken, with margin.
   localparam int DRAIN_CYCLES   = 6;
   // Length of the deliberate output hold-off, in clock cycles.
   localparam int RX_HOLD_CYCLES = 300;
   // Header and payload sizes of a minimal, well-formed ClientHello frame.
   localparam int MIN_IP_BYTES   = 20;
   localparam int MIN_TCP_BYTES  = 20;
   localparam int HELLO_BYTES    = PAY_OFS_VER_LO + 1;

   // Ways in which the result side accepts words.
   typedef enum int {
      RX_ALWAYS  = 0,
      RX_RANDOM  = 1,
      RX_PATTERN = 2,
      RX_SPARSE  = 3
   } rx_mode_type;

   // One predicted verdict word, field by field.
   typedef struct packed {
      verdict_type  verdict;
      logic         report;
      logic [15:0]  version;
      logic [31:0]  src;
      logic [31:0]  dst;
   } frame_verdict_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic [7:0]                req_tdata   = 8'd0;
   logic                      req_tlast   = 1'b0;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic                      csr_we      = 1'b0;
   logic [15:0]               csr_wdata   = 16'd0;

   // Verdicts still owed by the block, oldest first.
   frame_verdict_type pending_verdicts[$];
   // The frame being assembled by the directed and random tests.
   logic [7:0]     frame_bytes[$];
   int             fail_count = 0;

   // Sender and receiver behaviour, changed by the tests between phases.
   bit             sender_bursty   = 1'b1;
   int             burst_left      = 0;
   rx_mode_type    rx_mode         = RX_RANDOM;
   bit             rx_hold_request = 1'b0;

   // Our own copy of the parser state and the min_version register.
   logic [POS_BITS-1:0] pos;
   logic [3:0]          ip_words;
   logic [3:0]          tcp_words;
   logic [7:0]          proto;
   logic [7:0]          rec_type;
   logic [7:0]          hs_type;
   logic [31:0]         src_addr;
   logic [31:0]         dst_addr;
   logic [15:0]         hello_ver;
   logic [3:0]          seen;
   logic [15:0]         min_version;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tls_client_hello_version_filter_core #(
      .LINK_HEADER_BYTES (LINK_BYTES),
      .POSITION_BITS     (POS_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Every field of a frame is forgotten once its last byte has been seen.
   function automatic void clear_frame_state();
      pos       = '0;
      ip_words  = '0;
      tcp_words = '0;
      proto     = '0;
      rec_type  = '0;
      hs_type   = '0;
      src_addr  = '0;
      dst_addr  = '0;
      hello_ver = '0;
      seen      = '0;
   endfunction

   // Advances the parser by one accepted byte. Returns 1, with the verdict in
   // res, when the byte closes its frame.
   function automatic bit predict_frame_byte(input logic [7:0] b, input logic last,
                                             output frame_verdict_type res);
      int p;
      int tcp_pos;
      int pay;
      verdict_type v;
      p       = pos;
      // Both offsets use the header length known before this byte; only the
      // TCP offset is refreshed when this byte is the IP header length itself.
      tcp_pos = LINK_BYTES + 4 * ip_words + TCP_OFS_DOFF;
      pay     = LINK_BYTES + 4 * ip_words + 4 * tcp_words;
      res     = '0;

      if (p == LINK_BYTES) begin
         ip_words = b[3:0];
         tcp_pos  = LINK_BYTES + 4 * ip_words + TCP_OFS_DOFF;
      end else if (p == LINK_BYTES + IP_OFS_PROTOCOL) begin
         proto = b;
      end else if (p >= LINK_BYTES + IP_OFS_SRC && p < LINK_BYTES + IP_OFS_DST) begin
         src_addr = {src_addr[23:0], b};
      end else if (p >= LINK_BYTES + IP_OFS_DST && p < LINK_BYTES + IP_OFS_END) begin
         dst_addr = {dst_addr[23:0], b};
      end

      // With a short IP header the data offset may land on an address byte;
      // both are then taken from the same byte.
      if (p > LINK_BYTES && p == tcp_pos) begin
         tcp_words = b[7:4];
      end else if (p > LINK_BYTES && p > tcp_pos) begin
         if (p == pay + PAY_OFS_RECORD) begin
            rec_type           = b;
            seen[SEEN_RECORD]  = 1'b1;
         end else if (p == pay + PAY_OFS_HS_TYPE) begin
            hs_type            = b;
            seen[SEEN_HS_TYPE] = 1'b1;
         end else if (p == pay + PAY_OFS_VER_HI) begin
            hello_ver[15:8]    = b;
            seen[SEEN_VER_HI]  = 1'b1;
         end else if (p == pay + PAY_OFS_VER_LO) begin
            hello_ver[7:0]     = b;
            seen[SEEN_VER_LO]  = 1'b1;
         end
      end

      // The position holds at its maximum on very long frames.
      if (pos != '1) pos = pos + 1'b1;
      if (!last) return 1'b0;

      // Checks run in header order; a check whose byte never came gives
      // truncation instead.
      if (p < LINK_BYTES)                             v = VERDICT_TRUNCATED;
      else if (ip_words < MIN_HDR_WORDS)              v = VERDICT_BAD_IP_LEN;
      else if (p < LINK_BYTES + IP_OFS_PROTOCOL)      v = VERDICT_TRUNCATED;
      else if (proto != IP_PROTO_TCP)                 v = VERDICT_NOT_TCP;
      else if (p < tcp_pos)                           v = VERDICT_TRUNCATED;
      else if (tcp_words < MIN_HDR_WORDS)             v = VERDICT_BAD_TCP_LEN;
      else if (!seen[SEEN_RECORD])                    v = VERDICT_TRUNCATED;
      else if (rec_type != TLS_CT_HANDSHAKE)          v = VERDICT_NOT_HANDSHAKE;
      else if (!seen[SEEN_HS_TYPE])                   v = VERDICT_TRUNCATED;
      else if (hs_type != TLS_HS_CLIENT_HELLO)        v = VERDICT_NOT_HELLO;
      else if (!(seen[SEEN_VER_HI] && seen[SEEN_VER_LO])) v = VERDICT_TRUNCATED;
      else if (hello_ver < min_version)               v = VERDICT_OLD_VERSION;
      else                                            v = VERDICT_VERSION_OK;

      res.verdict = v;
      res.report  = (v == VERDICT_OLD_VERSION);
      res.version = hello_ver;
      res.src     = src_addr;
      res.dst     = dst_addr;
      clear_frame_state();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted result word is matched against the oldest prediction.
   always @(posedge clock) begin : result_check
      frame_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result word %h arrived with no frame outstanding", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("verdict", want.verdict, rsp_tdata[2:0]);
            check_field("report", want.report, rsp_tdata[3]);
            check_field("client_version", want.version, rsp_tdata[19:4]);
            check_field("source_address", want.src, rsp_tdata[51:20]);
            check_field("destination_address", want.dst, rsp_tdata[83:52]);
            check_field("padding", 32'd0, rsp_tdata[87:84]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: ready follows the current mode, with an occasional long
   // hold-off requested by a test and counted here.
   // ------------------------------------------------------------------

   initial begin : receiver
      int rx_count;
      rx_count = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_tready <= ((rx_count % 5) >= 2);
            default:    rsp_tready <= ($urandom_range(0, 9) < 3);
         endcase
         rx_count++;
      end
   end

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------

   // Offers one byte and waits until the block takes it. In bursty mode the
   // sender pauses between bursts of random length.
   task automatic send_word(input logic [7:0] b, input logic last);
      frame_verdict_type res;
      if (sender_bursty) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (predict_frame_byte(b, last, res)) pending_verdicts.push_back(res);
   endtask

   // Sends the assembled frame, or only its first cut bytes when cut is
   // between 1 and the frame length; the final byte sent carries tlast.
   task automatic send_frame(input int cut);
      int n;
      n = (cut <= 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
      for (int i = 0; i < n; i++) send_word(frame_bytes[i], i == n - 1);
   endtask

   task automatic release_sender();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   // Waits for every owed verdict, then for the pipeline to settle, so that
   // the block is idle afterwards. The final wait also ensures that time moves
   // on before the next write to any input.
   task automatic wait_drain();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_min_version(input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      min_version = value;
      @(posedge clock);
   endtask

   // Builds an Ethernet/IPv4/TCP frame with a TLS record in front of the
   // payload. Short header lengths still get a 20 byte header so that the
   // addresses are present. All other bytes are random.
   function automatic void build_frame(input logic [3:0] ihl, input logic [7:0] ip_proto,
                                       input logic [3:0] doff, input logic [7:0] rec,
                                       input logic [7:0] hs, input logic [15:0] ver,
                                       input int extra);
      int ip_len;
      int tcp_len;
      ip_len  = (ihl < MIN_HDR_WORDS) ? MIN_IP_BYTES : 4 * ihl;
      tcp_len = (doff < MIN_HDR_WORDS) ? MIN_TCP_BYTES : 4 * doff;
      frame_bytes.delete();
      repeat (LINK_BYTES) frame_bytes.push_back(8'($urandom));
      for (int i = 0; i < ip_len; i++) begin
         if (i == 0)                    frame_bytes.push_back({4'($urandom), ihl});
         else if (i == IP_OFS_PROTOCOL) frame_bytes.push_back(ip_proto);
         else                           frame_bytes.push_back(8'($urandom));
      end
      for (int i = 0; i < tcp_len; i++) begin
         if (i == TCP_OFS_DOFF) frame_bytes.push_back({doff, 4'($urandom)});
         else                   frame_bytes.push_back(8'($urandom));
      end
      for (int i = 0; i < HELLO_BYTES + extra; i++) begin
         case (i)
            PAY_OFS_RECORD:  frame_bytes.push_back(rec);
            PAY_OFS_HS_TYPE: frame_bytes.push_back(hs);
            PAY_OFS_VER_HI:  frame_bytes.push_back(ver[15:8]);
            PAY_OFS_VER_LO:  frame_bytes.push_back(ver[7:0]);
            default:         frame_bytes.push_back(8'($urandom));
         endcase
      end
   endfunction

   // A minimal, well-formed ClientHello with the given version.
   task automatic send_hello(input logic [15:0] ver, input int cut);
      build_frame(MIN_HDR_WORDS, IP_PROTO_TCP, MIN_HDR_WORDS, TLS_CT_HANDSHAKE,
                  TLS_HS_CLIENT_HELLO, ver, 0);
      send_frame(cut);
   endtask

   // Mostly well-formed ClientHellos with random contents; the rest break
   // header fields, carry another record or handshake type, or end early.
   task automatic send_random_frame(output int sent);
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [7:0]  ip_proto;
      logic [7:0]  rec;
      logic [7:0]  hs;
      logic [15:0] ver;
      int          pick;
      int          cut;

      pick = $urandom_range(0, 9);
      if (pick < 6)       ihl = MIN_HDR_WORDS;
      else if (pick < 8)  ihl = 4'($urandom_range(6, 15));
      else if (pick == 8) ihl = 4'($urandom_range(0, 4));
      else                ihl = 4'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6)       doff = MIN_HDR_WORDS;
      else if (pick < 8)  doff = 4'($urandom_range(6, 15));
      else if (pick == 8) doff = 4'($urandom_range(0, 4));
      else                doff = 4'($urandom);
      ip_proto = ($urandom_range(0, 9) != 0) ? IP_PROTO_TCP : 8'($urandom);
      rec      = ($urandom_range(0, 9) != 0) ? TLS_CT_HANDSHAKE : 8'($urandom);
      hs       = ($urandom_range(0, 9) != 0) ? TLS_HS_CLIENT_HELLO : 8'($urandom);
      // Versions cluster around the threshold so that both outcomes and the
      // boundary itself come up often.
      case ($urandom_range(0, 4))
         0:       ver = min_version - 1'b1;
         1:       ver = min_version;
         2:       ver = min_version + 1'b1;
         3:       ver = {8'h03, 8'($urandom_range(0, 4))};
         default: ver = 16'($urandom);
      endcase
      build_frame(ihl, ip_proto, doff, rec, hs, ver, $urandom_range(0, 12));
      cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_bytes.size()) : 0;
      sent = (cut == 0) ? frame_bytes.size() : cut;
      send_frame(cut);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // The reset threshold reports versions below TLS 1.0 only.
   task automatic test_reset_minimum();
      send_hello(16'h0300, 0);
      send_hello(16'h0301, 0);
      send_hello(16'h0000, 0);
      release_sender();
      wait_drain();
   endtask

   // Frames for each rejection reason but truncation, including a zero header length.
   task automatic test_verdict_codes();
      build_frame(4'd4, IP_PROTO_TCP, MIN_HDR_WORDS, TLS_CT_HANDSHAKE,
                  TLS_HS_CLIENT_HELLO, 16'h0300, 0);
      send_frame(0);
      build_frame(4'd0, IP_PROTO_TCP, MIN_HDR_WORDS, TLS_CT_HANDSHAKE,
                  TLS_HS_CLIENT_HELLO, 16'h0300, 0);
      send_frame(0);
      build_frame(MIN_HDR_WORDS, 8'd17, MIN_HDR_WORDS, TLS_CT_HANDSHAKE,
                  TLS_HS_CLIENT_HELLO, 16'h0300, 0);
      send_frame(0);
      build_frame(MIN_HDR_WORDS, IP_PROTO_TCP, 4'd4, TLS_CT_HANDSHAKE,
                  TLS_HS_CLIENT_HELLO, 16'h0300, 0);
      send_frame(0);
      build_frame(MIN_HDR_WORDS, IP_PROTO_TCP, MIN_HDR_WORDS, 8'd23,
                  TLS_HS_CLIENT_HELLO, 16'h0300, 0);
      send_frame(0);
      build_frame(MIN_HDR_WORDS, IP_PROTO_TCP, MIN_HDR_WORDS, TLS_CT_HANDSHAKE,
                  8'd2, 16'h0300, 0);
      send_frame(0);
      release_sender();
      wait_drain();
   endtask

   // A minimal hello cut just after each byte that a check needs, and just before
   // most of them: link header, header length, protocol, data offset, record type,
   // handshake type and both version bytes. Cuts on a single byte included.
   task automatic test_truncation();
      int pay;
      pay = LINK_BYTES + MIN_IP_BYTES + MIN_TCP_BYTES;
      send_hello(16'h0300, 1);
      send_hello(16'h0300, LINK_BYTES);
      send_hello(16'h0300, LINK_BYTES + 1);
      send_hello(16'h0300, LINK_BYTES + IP_OFS_PROTOCOL);
      send_hello(16'h0300, LINK_BYTES + IP_OFS_PROTOCOL + 1);
      send_hello(16'h0300, LINK_BYTES + MIN_IP_BYTES + TCP_OFS_DOFF);
      send_hello(16'h0300, LINK_BYTES + MIN_IP_BYTES + TCP_OFS_DOFF + 1);
      send_hello(16'h0300, pay + PAY_OFS_RECORD + 1);
      send_hello(16'h0300, pay + PAY_OFS_HS_TYPE);
      send_hello(16'h0300, pay + PAY_OFS_HS_TYPE + 1);
      send_hello(16'h0300, pay + PAY_OFS_VER_HI + 1);
      send_hello(16'h0300, pay + PAY_OFS_VER_LO + 1);
      release_sender();
      wait_drain();
   endtask

   // Threshold and field extremes, longest headers, and frames of all ones
   // and all zeros.
   task automatic test_extremes();
      write_min_version(16'hFFFF);
      send_hello(16'hFFFF, 0);
      send_hello(16'hFFFE, 0);
      build_frame(4'd15, IP_PROTO_TCP, 4'd15, TLS_CT_HANDSHAKE,
                  TLS_HS_CLIENT_HELLO, 16'h0000, 3);
      send_frame(0);
      frame_bytes.delete();
      repeat (80) frame_bytes.push_back(8'hFF);
      send_frame(0);
      frame_bytes.delete();
      repeat (80) frame_bytes.push_back(8'h00);
      send_frame(0);
      release_sender();
      wait_drain();
      write_min_version(16'h0000);
      send_hello(16'h0000, 0);
      send_hello(16'hFFFF, 0);
      release_sender();
      wait_drain();
   endtask

   // A frame longer than the position counter can count: the counter must
   // saturate and the trailing bytes must not disturb the verdict. The frame
   // after it checks that the position starts again from zero.
   task automatic test_long_frame();
      write_min_version(16'h0303);
      sender_bursty = 1'b0;
      rx_mode       = RX_ALWAYS;
      build_frame(MIN_HDR_WORDS, IP_PROTO_TCP, MIN_HDR_WORDS, TLS_CT_HANDSHAKE,
                  TLS_HS_CLIENT_HELLO, 16'h0302,
                  (1 << POS_BITS) + 40 - (LINK_BYTES + MIN_IP_BYTES + MIN_TCP_BYTES
                                          + HELLO_BYTES));
      send_frame(0);
      send_hello(16'h0303, 0);
      release_sender();
      wait_drain();
      sender_bursty = 1'b1;
      rx_mode       = RX_RANDOM;
   endtask

   // The result side holds off for a long stretch while short frames keep
   // coming, so the output register fills and the block must stall its input.
   task automatic test_output_backpressure();
      sender_bursty   = 1'b0;
      rx_hold_request = 1'b1;
      for (int i = 0; i < 6; i++) begin
         build_frame(MIN_HDR_WORDS, IP_PROTO_TCP, MIN_HDR_WORDS, TLS_CT_HANDSHAKE,
                     TLS_HS_CLIENT_HELLO, 16'($urandom), 0);
         send_frame($urandom_range(1, 6));
      end
      send_hello(16'h0302, 0);
      send_hello(16'h0301, 0);
      release_sender();
      wait_drain();
      sender_bursty = 1'b1;
   endtask

   // Four phases at different thresholds. The first runs with no idling on
   // either side; the others mix sender bursts with each receiver mode.
   task automatic test_random_traffic();
      logic [15:0] phase_min[4];
      int          bytes_sent;
      int          frames_sent;
      int          n;
      phase_min = '{16'h0303, 16'($urandom), 16'h0302, 16'($urandom)};
      for (int ph = 0; ph < 4; ph++) begin
         write_min_version(phase_min[ph]);
         sender_bursty = (ph != 0);
         rx_mode       = rx_mode_type'(ph);
         bytes_sent    = 0;
         frames_sent   = 0;
         while (bytes_sent < 200 || frames_sent < 3) begin
            send_random_frame(n);
            bytes_sent += n;
            frames_sent++;
         end
         release_sender();
         wait_drain();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------

   initial begin
      clear_frame_state();
      min_version = MIN_VERSION_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_minimum();
      test_verdict_codes();
      test_truncation();
      test_extremes();
      test_long_frame();
      test_output_backpressure();
      test_random_traffic();

      wait_drain();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/tchvf_pkg.sv
hw/rtl/tls_client_hello_version_filter_core.sv
sim/tls_client_hello_version_filter_core_test.sv
